FILE: sv/button_press_classifier_macros.svh
// Assertion macros shared by the button press classifier RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bpc_pkg.sv
// Package for the button press classifier: state, status and configuration
// types, register indexes and reset values. No dependencies.
package bpc_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned DEB_W      = 16;
    localparam int unsigned THR_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [THR_W-1:0] LONG_PRESS_RST = 24'd1000;
    localparam logic [THR_W-1:0] TIMEOUT_RST    = 24'd10000;

    // Status flags, one per result field.
    typedef struct packed {
        logic timeout;
        logic long_press;
        logic releasing;
        logic pressing;
        logic released;
        logic pressed;
    } status_t;

    // Everything the classifier carries from one tick to the next.
    typedef struct packed {
        status_t            status;
        logic [TIME_W-1:0]  press_start;
        logic [TIME_W-1:0]  last_press;
        logic               lock;
    } state_t;

    typedef struct packed {
        logic [DEB_W-1:0] debounce;
        logic [THR_W-1:0] long_press;
        logic [THR_W-1:0] timeout;
    } cfg_t;

endpackage

FILE: sv/bpc_step.sv
// One classification step of the button press classifier: next state from
// the current state, the configuration and one tick. Depends on bpc_pkg.
module bpc_step
(
    input  bpc_pkg::state_t              cur,
    input  bpc_pkg::cfg_t                cfg,
    input  logic [bpc_pkg::TIME_W-1:0]   now_ms,
    input  logic                         pin_level,
    output bpc_pkg::state_t              nxt
);

    logic [bpc_pkg::TIME_W-1:0] since_press;
    logic [bpc_pkg::TIME_W-1:0] held;
    logic                       active;
    logic                       level_eff;
    logic                       hit_timeout;
    logic                       long_hit;

    // Both differences wrap modulo 2^32; a zero start time means unknown.
    assign since_press = now_ms - cur.last_press;
    assign held        = (cur.press_start != '0) ? (now_ms - cur.press_start) : '0;
    assign active      = since_press >= {{(bpc_pkg::TIME_W-bpc_pkg::DEB_W){1'b0}}, cfg.debounce};
    assign level_eff   = pin_level && !cur.lock;
    assign hit_timeout = level_eff &&
        (held >= {{(bpc_pkg::TIME_W-bpc_pkg::THR_W){1'b0}}, cfg.timeout});
    assign long_hit    =
        (held > {{(bpc_pkg::TIME_W-bpc_pkg::THR_W){1'b0}}, cfg.long_press}) &&
        (held < {{(bpc_pkg::TIME_W-bpc_pkg::THR_W){1'b0}}, cfg.timeout});

    always_comb
    begin
        nxt = cur;
        if (active)
        begin
            nxt.status.timeout    = 1'b0;
            nxt.status.pressing   = 1'b0;
            nxt.status.releasing  = 1'b0;
            nxt.status.long_press = 1'b0;

            if (cur.lock && !pin_level)
            begin
                nxt.lock = 1'b0;
            end

            if (level_eff)
            begin
                // A timeout ends the press with a zero held time, so it never
                // counts as long; the fresh press follows in the same tick.
                if (hit_timeout)
                begin
                    nxt.status.timeout   = 1'b1;
                    nxt.status.releasing = 1'b1;
                    nxt.lock             = 1'b1;
                end
                if (hit_timeout || cur.status.released)
                begin
                    nxt.press_start      = now_ms;
                    nxt.last_press       = now_ms;
                    nxt.status.pressing  = 1'b1;
                end
                nxt.status.pressed  = 1'b1;
                nxt.status.released = 1'b0;
            end
            else
            begin
                if (cur.status.pressed)
                begin
                    nxt.status.releasing  = 1'b1;
                    nxt.status.long_press = long_hit;
                end
                nxt.status.released = 1'b1;
                nxt.status.pressed  = 1'b0;
                nxt.press_start     = '0;
            end
        end
    end

endmodule

FILE: sv/button_press_classifier.sv
// Button press classifier: debounce, long press and timeout detection.
// A tick passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while out_ready allows; the state update is a single registered pass.
// Reset (rst_n, asynchronous, active low) clears status, times and the lock,
// and loads the register defaults. Depends on bpc_pkg, bpc_step and the macro
// header button_press_classifier_macros.svh.
`include "button_press_classifier_macros.svh"

module button_press_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpc_pkg::TIME_W-1:0]          now_ms,
    input  logic                                pin_level,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_pressed,
    output logic                                is_released,
    output logic                                press_event,
    output logic                                release_event,
    output logic                                long_press_event,
    output logic                                timeout_event
);

    // The configuration registers. The user must write them only while idle; the
    // block itself does not enforce it and has no interlock with the datapath.
    bpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= bpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press <= bpc_pkg::LONG_PRESS_RST;
            cfg_reg.timeout    <= bpc_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_DEBOUNCE:   cfg_reg.debounce   <= cfg_wdata[bpc_pkg::DEB_W-1:0];
                bpc_pkg::REG_LONG_PRESS: cfg_reg.long_press <= cfg_wdata;
                bpc_pkg::REG_TIMEOUT:    cfg_reg.timeout    <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // The pipeline has two stages: an input register holding the accepted
    // tick, and the result register. The classification step sits between
    // them and commits the state at the same edge it loads the result, so
    // the next tick in the input register always sees the updated state.
    logic                          in_valid_reg;
    logic [bpc_pkg::TIME_W-1:0]    in_now_reg;
    logic                          in_level_reg;
    logic                          out_valid_reg;
    bpc_pkg::status_t              out_status_reg;
    bpc_pkg::state_t               state_reg;
    bpc_pkg::state_t               state_next;

    logic out_load;
    logic in_load;

    // The result register takes a new value when it is empty or its
    // transfer completes in this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    bpc_step u_step
    (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .now_ms    (in_now_reg),
        .pin_level (in_level_reg),
        .nxt       (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_now_reg   <= now_ms;
            in_level_reg <= pin_level;
        end
        if (out_load)
        begin
            out_status_reg <= state_next.status;
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_pressed       = out_status_reg.pressed;
    assign is_released      = out_status_reg.released;
    assign press_event      = out_status_reg.pressing;
    assign release_event    = out_status_reg.releasing;
    assign long_press_event = out_status_reg.long_press;
    assign timeout_event    = out_status_reg.timeout;

    // A timeout always ends the press and starts a new one in the same tick.
    `BPC_ASSERT_NOW(a_timeout_restarts, out_valid_reg && out_status_reg.timeout,
        out_status_reg.releasing && out_status_reg.pressing && out_status_reg.pressed,
        "timeout without release and new press")
    // Held and released are never counted at once.
    `BPC_ASSERT_NOW(a_status_exclusive, out_valid_reg,
        !(out_status_reg.pressed && out_status_reg.released),
        "pressed and released both set")
    // A known start time exists only while the button is held.
    `BPC_ASSERT_NOW(a_start_when_held, state_reg.press_start != '0,
        state_reg.status.pressed, "press start time kept while not held")
    // A held timeout flag means the lock is still engaged.
    `BPC_ASSERT_NOW(a_timeout_locks, state_reg.status.timeout, state_reg.lock,
        "timeout flag without lock")
    // A timeout step engages the lock at the next cycle.
    `BPC_ASSERT_NEXT(a_lock_follows, out_load && state_next.status.timeout
        && !state_reg.status.timeout, state_reg.lock, "lock not set after timeout")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for button_press_classifier: directed and random ticks
// against a behavioral model of the debounce, long press and timeout rules.
// Depends on bpc_pkg and the button_press_classifier RTL.
module testbench;

    // Writes to this index must be ignored by the block.
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Slowest correct run is roughly 1100 items plus the register write phases;
    // the limit leaves a wide margin above that.
    localparam int CYCLE_LIMIT = 300000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [bpc_pkg::TIME_W-1:0]     now_ms = '0;
    logic                           pin_level = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           is_pressed;
    logic                           is_released;
    logic                           press_event;
    logic                           release_event;
    logic                           long_press_event;
    logic                           timeout_event;

    button_press_classifier DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .now_ms           (now_ms),
        .pin_level        (pin_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_pressed       (is_pressed),
        .is_released      (is_released),
        .press_event      (press_event),
        .release_event    (release_event),
        .long_press_event (long_press_event),
        .timeout_event    (timeout_event)
    );

    always #5 clk = ~clk;

    // Model of the classifier, at the widths of the block and starting from
    // its reset values.
    bpc_pkg::status_t           cur_status = '0;
    logic [bpc_pkg::TIME_W-1:0] start_ms = '0;
    logic [bpc_pkg::TIME_W-1:0] last_start_ms = '0;
    logic                       lock_active = 1'b0;
    logic [bpc_pkg::DEB_W-1:0]  deb_window = bpc_pkg::DEBOUNCE_RST;
    logic [bpc_pkg::THR_W-1:0]  long_limit = bpc_pkg::LONG_PRESS_RST;
    logic [bpc_pkg::THR_W-1:0]  timeout_limit = bpc_pkg::TIMEOUT_RST;

    bpc_pkg::status_t pending_status[$];
    int               mismatches = 0;
    int               burst_left = 0;
    int               cycle_count = 0;

    string field_name[6] = '{"is_pressed", "is_released", "press_event",
                             "release_event", "long_press_event", "timeout_event"};

    // A start time of zero stands for an unknown start, so the held time is zero.
    function automatic logic [bpc_pkg::TIME_W-1:0] held_for(
        input logic [bpc_pkg::TIME_W-1:0] stamp);
        return (start_ms != '0) ? stamp - start_ms : '0;
    endfunction

    function automatic void flag_release(input logic [bpc_pkg::TIME_W-1:0] stamp);
        logic [bpc_pkg::TIME_W-1:0] held;
        held = held_for(stamp);
        cur_status.releasing = 1'b1;
        if (held > {8'd0, long_limit} && held < {8'd0, timeout_limit})
            cur_status.long_press = 1'b1;
    endfunction

    function automatic void mark_released();
        cur_status.released = 1'b1;
        cur_status.pressed  = 1'b0;
        start_ms = '0;
    endfunction

    // Advances the model by one tick and returns the status the block must show.
    function automatic bpc_pkg::status_t classify_tick(
        input logic [bpc_pkg::TIME_W-1:0] stamp,
        input logic                       raw_level);
        logic                       level;
        logic [bpc_pkg::TIME_W-1:0] since_press;
        level = raw_level;
        since_press = stamp - last_start_ms;
        // Inside the debounce window the tick leaves everything as it was.
        if (since_press >= {16'd0, deb_window})
        begin
            cur_status.timeout    = 1'b0;
            cur_status.pressing   = 1'b0;
            cur_status.releasing  = 1'b0;
            cur_status.long_press = 1'b0;
            // After a timeout the level reads low until the pin really drops.
            if (lock_active)
            begin
                if (!level)
                    lock_active = 1'b0;
                level = 1'b0;
            end
            if (level)
            begin
                // The release comes first and clears the start time, so the
                // release a timeout causes can never count as a long press.
                if (held_for(stamp) >= {8'd0, timeout_limit})
                begin
                    cur_status.timeout = 1'b1;
                    lock_active = 1'b1;
                    mark_released();
                    flag_release(stamp);
                end
                if (cur_status.released)
                begin
                    start_ms = stamp;
                    last_start_ms = stamp;
                    cur_status.pressing = 1'b1;
                end
                cur_status.pressed  = 1'b1;
                cur_status.released = 1'b0;
            end
            else
            begin
                if (cur_status.pressed)
                    flag_release(stamp);
                mark_released();
            end
        end
        return cur_status;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Sends one tick. The sender works in bursts; a new burst may start after
    // a gap with valid low, and some bursts follow with no gap at all.
    task automatic send_tick(input logic [bpc_pkg::TIME_W-1:0] stamp, input logic level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        now_ms    <= stamp;
        pin_level <= level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_status.push_back(classify_tick(stamp, level));
    endtask

    // Register writes happen only with the block idle: every tick gives exactly
    // one result, so an empty expectation queue means nothing is in flight.
    task automatic write_register(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bpc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bpc_pkg::REG_DEBOUNCE:   deb_window = data[bpc_pkg::DEB_W-1:0];
            bpc_pkg::REG_LONG_PRESS: long_limit = data;
            bpc_pkg::REG_TIMEOUT:    timeout_limit = data;
            default:                 ;
        endcase
        burst_left = 0;
    endtask

    task automatic set_thresholds(input logic [bpc_pkg::DEB_W-1:0] deb,
                                  input logic [bpc_pkg::THR_W-1:0] lng,
                                  input logic [bpc_pkg::THR_W-1:0] tmo);
        logic [7:0] junk;
        // Upper bits of the debounce write are junk that the block must drop.
        junk = 8'($urandom_range(0, 255));
        write_register(bpc_pkg::REG_DEBOUNCE, {junk, deb});
        write_register(bpc_pkg::REG_LONG_PRESS, lng);
        write_register(bpc_pkg::REG_TIMEOUT, tmo);
    endtask

    // Runs under the reset thresholds: debounce 50, long press 1000, timeout 10000.
    task automatic test_startup_and_release();
        send_tick(32'd100, 1'b1);   // first high level: held, but no press transfer event
        send_tick(32'd200, 1'b0);
        send_tick(32'd300, 1'b1);
        send_tick(32'd400, 1'b0);
    endtask

    task automatic test_press_at_zero();
        // A press at time zero leaves the start unknown, so the long hold that
        // follows does not count as a long press.
        send_tick(32'd0, 1'b1);
        send_tick(32'd1500, 1'b0);
    endtask

    task automatic test_debounce_window();
        send_tick(32'd1510, 1'b1);
        send_tick(32'd1520, 1'b0);
        send_tick(32'd1559, 1'b0);
        send_tick(32'd1560, 1'b0);  // first tick past the window
    endtask

    task automatic test_long_press();
        send_tick(32'd2000, 1'b1);
        send_tick(32'd3001, 1'b0);  // held 1001: long press
        send_tick(32'd3500, 1'b1);
        send_tick(32'd4500, 1'b0);  // held exactly 1000: not long
    endtask

    task automatic test_timeout_and_lock();
        send_tick(32'd5000, 1'b1);
        send_tick(32'd15000, 1'b1);  // timeout, release, then a new press
        send_tick(32'd15100, 1'b1);  // locked: reads low although the pin is high
        send_tick(32'd15200, 1'b1);
        send_tick(32'd15300, 1'b0);  // the pin drops and the lock clears
        send_tick(32'd15400, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_register_extremes();
        write_register(REG_UNUSED, 24'hFFFFFF);
        set_thresholds(16'd0, 24'd0, 24'd0);
        // With a zero timeout a high level times out at once and locks, so the next high tick reads low.
        send_tick(32'h1000_0000, 1'b1);
        send_tick(32'h1000_0001, 1'b1);
        set_thresholds(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_tick(32'h2000_0000, 1'b0);
        send_tick(32'h2000_0001, 1'b1);
    endtask

    // Random phases, each with its own thresholds and a time walk whose steps
    // suit them, so that debounce, long press and timeout all come up often.
    task automatic test_random_phases(input int phases, input int per_phase);
        int                         kind;
        int                         span;
        int                         run_left;
        int                         pick;
        logic [bpc_pkg::DEB_W-1:0]  deb;
        logic [bpc_pkg::THR_W-1:0]  lng;
        logic [bpc_pkg::THR_W-1:0]  tmo;
        logic [bpc_pkg::TIME_W-1:0] tick_ms;
        logic [bpc_pkg::TIME_W-1:0] step;
        logic                       held_level;
        logic                       level;
        for (int p = 0; p < phases; p++)
        begin
            kind = p % 4;
            case (kind)
                0:
                begin
                    deb  = 16'($urandom_range(0, 3));
                    lng  = 24'($urandom_range(0, 15));
                    tmo  = 24'($urandom_range(0, 40));
                    span = $urandom_range(1, 4);
                end
                1:
                begin
                    deb  = bpc_pkg::DEBOUNCE_RST;
                    lng  = bpc_pkg::LONG_PRESS_RST;
                    tmo  = bpc_pkg::TIMEOUT_RST;
                    span = 700;
                end
                2:
                begin
                    deb  = 16'($urandom_range(0, 300));
                    lng  = 24'($urandom_range(0, 3000));
                    tmo  = 24'($urandom_range(0, 6000));
                    span = 400;
                end
                default:
                begin
                    // The first extreme phase takes every maximum, the second
                    // every zero, later ones a random mix of the two.
                    if (p / 4 == 0)
                    begin
                        deb = 16'hFFFF;
                        lng = 24'hFFFFFF;
                        tmo = 24'hFFFFFF;
                    end
                    else if (p / 4 == 1)
                    begin
                        deb = '0;
                        lng = '0;
                        tmo = '0;
                    end
                    else
                    begin
                        deb = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
                        lng = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
                        tmo = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
                    end
                    span = 1 << 21;
                end
            endcase
            set_thresholds(deb, lng, tmo);
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNUSED, 24'($urandom_range(0, 24'hFFFFFF)));

            pick = $urandom_range(0, 3);
            if (pick == 0)
                tick_ms = '0;
            else if (pick == 1)
                tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            else
                tick_ms = $urandom();
            held_level = 1'($urandom_range(0, 1));
            run_left = 0;

            for (int i = 0; i < per_phase; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    step = $urandom_range(0, span);
                else if (pick < 90)
                    step = $urandom_range(0, 3);
                else
                    step = $urandom();
                tick_ms = tick_ms + step;
                // The pin holds a level for a run of ticks; now and then a
                // single tick carries a random level as noise.
                if (run_left == 0)
                begin
                    held_level = ~held_level;
                    run_left = $urandom_range(1, 10);
                end
                run_left--;
                level = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : held_level;
                send_tick(tick_ms, level);
            end
        end
    endtask

    // The receiver switches between patterns of its own: always ready, random
    // stalls, and ready on only one cycle in five.
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
        end
        else
            mode_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (stall_tick % 5 == 0);
        endcase
    end

    // Each result transfer is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin
        bpc_pkg::status_t got;
        bpc_pkg::status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {timeout_event, long_press_event, release_event, press_event,
                   is_released, is_pressed};
            if (pending_status.size() == 0)
                report_mismatch("result transfer with no expectation waiting");
            else
            begin
                want = pending_status.pop_front();
                for (int b = 0; b < 6; b++)
                    if (got[b] !== want[b])
                        report_mismatch($sformatf("%s is %b, expected %b",
                                                  field_name[b], got[b], want[b]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_startup_and_release();
        test_press_at_zero();
        test_debounce_window();
        test_long_press();
        test_timeout_and_lock();
        test_register_extremes();
        test_random_phases(21, 50);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        // Wait on to catch any stray result after the last one.
        repeat (8) @(posedge clk);
        if (pending_status.size() == 0 && mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_step.sv
sv/button_press_classifier.sv
sim/testbench.sv
